/* rtl/core/segment_tree_range_sum_macros.svh */
// Assertion macros shared by the segment tree range sum RTL
`ifndef SEGMENT_TREE_RANGE_SUM_MACROS_SVH
`define SEGMENT_TREE_RANGE_SUM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEGSUM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEGSUM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

// Invariant checked at every clock edge out of reset.
`define SEGSUM_ASSERT_ALW(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error(msg);

`endif

/* rtl/core/segsum_pkg.sv */
// Shared types and constants for the segment tree range sum block
`timescale 1ns / 1ps
`default_nettype none
package segsum_pkg;

	localparam int IDX_W  = 10;
	localparam int DATA_W = 32;
	localparam int SIZE_W = 11;
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam logic [PADDR_W-1:0] REG_SIZE_IN_USE = 2'd0;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic clr_wr;
		logic load_item;
		logic wr_leaf;
		logic up_wr;
		logic q_acc;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic is_query;
		logic wr_ok;
		logic q_err;
		logic at_root;
		logic q_more;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/core/segsum_req_if.sv */
// Request channel interface: action, index range and value
`timescale 1ns / 1ps
`default_nettype none
interface segsum_req_if import segsum_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [IDX_W-1:0]         index_low;
	logic [IDX_W-1:0]         index_high;
	logic signed [DATA_W-1:0] new_value;

	modport source (output valid, action, index_low, index_high, new_value, input ready);
	modport sink (input valid, action, index_low, index_high, new_value, output ready);
endinterface
`default_nettype wire

/* rtl/core/segsum_rsp_if.sv */
// Result channel interface: range sum and error flag
`timescale 1ns / 1ps
`default_nettype none
interface segsum_rsp_if import segsum_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] range_sum;
	logic                     range_error;

	modport source (output valid, range_sum, range_error, input ready);
	modport sink (input valid, range_sum, range_error, output ready);
endinterface
`default_nettype wire

/* rtl/core/segsum_dp.sv */
// Datapath: node sum memory, tree cursors, accumulator and result register
`timescale 1ns / 1ps
`default_nettype none
module segsum_dp import segsum_pkg::*; #(
	parameter int MAX_POSITIONS = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	output sts_t                          sts,
	input  wire logic                     in_action,
	input  wire logic [IDX_W-1:0]         in_index_low,
	input  wire logic [IDX_W-1:0]         in_index_high,
	input  wire logic signed [DATA_W-1:0] in_new_value,
	input  wire logic [SIZE_W-1:0]        size_in_use,
	output logic signed [DATA_W-1:0]      range_sum,
	output logic                          range_error
);

	localparam int NODES = 2 * MAX_POSITIONS;
	localparam int NW    = $clog2(NODES);
	localparam int RW    = $clog2(NODES + 1);
	localparam logic [NW-1:0] LEAF_BASE  = NW'(MAX_POSITIONS);
	localparam logic [RW-1:0] LEAF_BASER = RW'(MAX_POSITIONS);
	localparam logic [NW-1:0] LAST_NODE  = NW'(NODES - 1);

	logic [DATA_W-1:0] mem [NODES];

	logic              act_q;
	logic [IDX_W-1:0]  lo_q;
	logic [IDX_W-1:0]  hi_q;
	logic [DATA_W-1:0] val_q;
	logic [NW-1:0]     child_q;
	logic [DATA_W-1:0] carry_q;
	logic [RW-1:0]     l_q;
	logic [RW-1:0]     r_q;
	logic [DATA_W-1:0] acc_q;
	logic [NW-1:0]     clr_cnt_q;
	logic [DATA_W-1:0] rd0_q;
	logic [DATA_W-1:0] rd1_q;
	logic [DATA_W-1:0] sum_q;
	logic              err_q;

	logic [NW-1:0]     leaf;
	logic [NW-1:0]     parent;
	logic [DATA_W-1:0] up_sum;
	logic [NW-1:0]     raddr0;
	logic [NW-1:0]     raddr1;
	logic              we;
	logic [NW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [RW-1:0]     l_nx;
	logic [RW-1:0]     r_nx;
	logic [DATA_W-1:0] add_l;
	logic [DATA_W-1:0] add_r;

	assign leaf   = NW'(lo_q) + LEAF_BASE;
	assign parent = child_q >> 1;
	assign up_sum = carry_q + rd0_q;
	assign raddr0 = (act_q == ACT_QUERY) ? NW'(l_q) : (child_q ^ NW'(1));
	assign raddr1 = NW'(r_q - RW'(1));

	assign l_nx  = (l_q + RW'(l_q[0])) >> 1;
	assign r_nx  = (r_q - RW'(r_q[0])) >> 1;
	assign add_l = l_q[0] ? rd0_q : '0;
	assign add_r = r_q[0] ? rd1_q : '0;

	always_comb begin
		we    = 1'b0;
		waddr = clr_cnt_q;
		wdata = '0;
		if (cmd.clr_wr) begin
			we = 1'b1;
		end else if (cmd.wr_leaf) begin
			we    = 1'b1;
			waddr = leaf;
			wdata = val_q;
		end else if (cmd.up_wr) begin
			we    = 1'b1;
			waddr = parent;
			wdata = up_sum;
		end
	end

	always_comb begin
		sts.clr_last = (clr_cnt_q == LAST_NODE);
		sts.is_query = (act_q == ACT_QUERY);
		sts.wr_ok    = ({1'b0, lo_q} < size_in_use);
		sts.q_err    = (lo_q > hi_q) || ({1'b0, hi_q} >= size_in_use);
		sts.at_root  = (parent == NW'(1));
		sts.q_more   = (l_nx < r_nx);
	end

	// node memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd0_q <= mem[raddr0];
		rd1_q <= mem[raddr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q <= in_action;
			lo_q  <= in_index_low;
			hi_q  <= in_index_high;
			val_q <= in_new_value;
			l_q   <= RW'(in_index_low) + LEAF_BASER;
			r_q   <= RW'(in_index_high) + LEAF_BASER + RW'(1);
			acc_q <= '0;
		end
		if (cmd.wr_leaf) begin
			child_q <= leaf;
			carry_q <= val_q;
		end
		if (cmd.up_wr) begin
			child_q <= parent;
			carry_q <= up_sum;
		end
		if (cmd.q_acc) begin
			acc_q <= acc_q + add_l + add_r;
			l_q   <= l_nx;
			r_q   <= r_nx;
		end
		if (cmd.load_out) begin
			err_q <= sts.q_err;
			sum_q <= sts.q_err ? '0 : acc_q;
		end
	end

	assign range_sum   = sum_q;
	assign range_error = err_q;

endmodule
`default_nettype wire

/* rtl/core/segsum_ctrl.sv */
// Controller: sequences clearing, point updates, range queries and results
`timescale 1ns / 1ps
`default_nettype none
`include "segment_tree_range_sum_macros.svh"
module segsum_ctrl import segsum_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_UP_RD,
		S_UP_WR,
		S_Q_RD,
		S_Q_ACC,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR:  cmd.clr_wr    = 1'b1;
			S_IDLE:   cmd.load_item = in_valid;
			S_DECODE: cmd.wr_leaf   = !sts.is_query && sts.wr_ok;
			S_UP_WR:  cmd.up_wr     = 1'b1;
			S_Q_ACC:  cmd.q_acc     = 1'b1;
			S_RESULT: cmd.load_out  = slot_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (sts.is_query) begin
						state_q <= sts.q_err ? S_RESULT : S_Q_RD;
					end else begin
						state_q <= sts.wr_ok ? S_UP_RD : S_IDLE;
					end
				end
				S_UP_RD: state_q <= S_UP_WR;
				S_UP_WR: begin
					state_q <= sts.at_root ? S_IDLE : S_UP_RD;
				end
				S_Q_RD: state_q <= S_Q_ACC;
				S_Q_ACC: begin
					state_q <= sts.q_more ? S_Q_RD : S_RESULT;
				end
				S_RESULT: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	`SEGSUM_ASSERT_ALW(a_cmd_onehot, clk, arst_n, $onehot0(cmd), "two datapath commands at once")
	`SEGSUM_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.load_out, !out_valid_q || out_ready, "result overwritten before taken")
	`SEGSUM_ASSERT_NXT(a_clear_holds, clk, arst_n, state_q == S_CLEAR && !sts.clr_last, state_q == S_CLEAR && !in_ready, "clear pass left early")
	`SEGSUM_ASSERT_IMP(a_idle_quiet, clk, arst_n, in_ready, !cmd.clr_wr && !cmd.wr_leaf && !cmd.up_wr, "memory written while idle")

endmodule
`default_nettype wire

/* rtl/core/segment_tree_range_sum.sv */
// Top level: point-update range-sum segment tree with APB size register
//
//  channel  | role    | carries
//  ---------+---------+----------------------------------------------------
//  item     | sink    | action, index_low, index_high, new_value
//  result   | source  | range_sum, range_error (one per query, none per write)
//  apb      | slave   | size_in_use at byte address 0, read back on prdata
//
//  After reset a clearing pass zeroes all 2*MAX_POSITIONS nodes of the node
//  memory, one node a cycle; no request is taken meanwhile.
//  A write stores its leaf, then climbs the L tree levels above the leaf
//  (L = 10 at 1024 positions) with a read step and a write step per level;
//  a write past the size is dropped at decode. A query runs I loop passes
//  (at most L+1), each a read step on the registered memory read and then
//  an accumulate step; a bad range skips the passes.
//  A request is accepted only when idle; a finished result sits in an output
//  register, so a stalled result channel holds nothing back until the next
//  query reaches its result step, which then waits and keeps new requests out.
`timescale 1ns / 1ps
`default_nettype none
module segment_tree_range_sum import segsum_pkg::*; #(
	parameter int MAX_POSITIONS = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0]  pwdata,
	output logic      [PDATA_W-1:0]  prdata,
	output logic                     pready,
	segsum_req_if.sink               item,
	segsum_rsp_if.source             result
);

	// reset size is 1024 clamped to the tree's capacity
	localparam int SIZE_RST = (MAX_POSITIONS < 1024) ? MAX_POSITIONS : 1024;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] size_wr;
	logic              size_we;
	cmd_t              cmd;
	sts_t              sts;

	// config register: zero acts as one, anything above capacity as capacity
	assign size_we = psel && penable && pwrite && pready && (paddr == REG_SIZE_IN_USE);

	always_comb begin
		size_wr = pwdata[SIZE_W-1:0];
		if (pwdata[SIZE_W-1:0] == '0) begin
			size_wr = SIZE_W'(1);
		end else if (int'(pwdata[SIZE_W-1:0]) > MAX_POSITIONS) begin
			size_wr = SIZE_W'(MAX_POSITIONS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(SIZE_RST);
		end else if (size_we) begin
			size_q <= size_wr;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SIZE_IN_USE) ? PDATA_W'(size_q) : '0;

	// sequencer: owns handshakes and result valid
	segsum_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// node memory, cursors and the result payload register
	segsum_dp #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_action     (item.action),
		.in_index_low  (item.index_low),
		.in_index_high (item.index_high),
		.in_new_value  (item.new_value),
		.size_in_use   (size_q),
		.range_sum     (result.range_sum),
		.range_error   (result.range_error)
	);

endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking bench for the segment tree range sum block: requests, APB size, result check
`timescale 1ns / 1ps
module tb;
	import segsum_pkg::*;

	localparam int POSITIONS   = 1024;
	// A write yields no result, so wait past the end of its tree walk before
	// touching the size register or ending the run.
	localparam int SETTLE_CYC  = 60;
	// Slowest run: ~1000 requests, each with chained sender gaps, the block's
	// own walk and result stalls, plus the clearing pass, taken several times over.
	localparam int CYCLE_LIMIT = 600000;
	localparam int PRINT_CAP   = 100;

	typedef struct packed {
		logic                     action;
		logic [IDX_W-1:0]         index_low;
		logic [IDX_W-1:0]         index_high;
		logic signed [DATA_W-1:0] new_value;
	} seg_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sum;
		logic                     err;
	} sum_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// APB side, idle until a size write
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	segsum_req_if item_ch ();
	segsum_rsp_if result_ch ();

	// Request payload and valid are held in local regs and updated by NBA
	// only, so the block never sees them change inside its own edge.
	logic     req_valid = 1'b0;
	seg_req_t req_data = '0;
	logic     rsp_ready = 1'b0;

	assign item_ch.valid      = req_valid;
	assign item_ch.action     = req_data.action;
	assign item_ch.index_low  = req_data.index_low;
	assign item_ch.index_high = req_data.index_high;
	assign item_ch.new_value  = req_data.new_value;
	assign result_ch.ready    = rsp_ready;

	segment_tree_range_sum #(
		.MAX_POSITIONS(POSITIONS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.item   (item_ch),
		.result (result_ch)
	);

	// Shadow of the array: leaf values only. An inner node is just the sum of
	// its leaves, so a range sum over the leaves gives the same answer.
	logic [DATA_W-1:0] pos_value [POSITIONS] = '{default: '0};
	logic [SIZE_W-1:0] span_limit = SIZE_W'(POSITIONS);

	seg_req_t    request_q [$];   // requests waiting for the driver
	sum_answer_t owed_sums [$];   // query answers not yet seen on the result side

	int mismatches  = 0;
	int cycle_count = 0;
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;
	int src_gap = 0;
	int snk_gap = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Register value as the block uses it: 0 acts as 1, above max saturates.
	function automatic logic [SIZE_W-1:0] span_of(input logic [SIZE_W-1:0] raw);
		if (raw == '0)
			return SIZE_W'(1);
		if (raw > SIZE_W'(POSITIONS))
			return SIZE_W'(POSITIONS);
		return raw;
	endfunction

	// Append one request at the tail of the pending queue.
	function automatic void queue_request(input seg_req_t op);
		request_q.insert(request_q.size(), op);
	endfunction

	// Update the shadow for one accepted request; queries owe one answer.
	function automatic void apply_request(input seg_req_t op);
		sum_answer_t ans;
		logic [DATA_W-1:0] acc;
		int i;
		if (op.action == ACT_WRITE) begin
			// writes past the size are dropped silently
			if ({1'b0, op.index_low} < span_limit)
				pos_value[op.index_low] = op.new_value;
		end else begin
			acc = '0;
			if (op.index_low > op.index_high || {1'b0, op.index_high} >= span_limit) begin
				ans.sum = '0;
				ans.err = 1'b1;
			end else begin
				for (i = int'(op.index_low); i <= int'(op.index_high); i++)
					acc = acc + pos_value[i];   // wraps mod 2^32
				ans.sum = acc;
				ans.err = 1'b0;
			end
			owed_sums.insert(owed_sums.size(), ans);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t: mismatch on %s: got %08h, expected %08h", $realtime, what, got,
				want);
	endtask

	function automatic void add_write(input int pos, input logic [DATA_W-1:0] v,
			input logic [IDX_W-1:0] hi = '0);
		seg_req_t op;
		op.action     = ACT_WRITE;
		op.index_low  = IDX_W'(pos);
		op.index_high = hi;
		op.new_value  = v;
		queue_request(op);
	endfunction

	function automatic void add_query(input int lo, input int hi,
			input logic [DATA_W-1:0] v = '0);
		seg_req_t op;
		op.action     = ACT_QUERY;
		op.index_low  = IDX_W'(lo);
		op.index_high = IDX_W'(hi);
		op.new_value  = v;
		queue_request(op);
	endfunction

	// Well-formed requests stay inside the current size; noise requests have
	// every field fully random (bad ranges, writes past the size).
	function automatic seg_req_t random_request(input bit well_formed);
		seg_req_t op;
		int a;
		int b;
		int top;
		top = int'(span_limit) - 1;
		op.action     = 1'($urandom_range(0, 1));
		op.index_low  = IDX_W'($urandom);
		op.index_high = IDX_W'($urandom);
		op.new_value  = DATA_W'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: op.new_value = 32'h7FFF_FFFF;
				1: op.new_value = 32'h8000_0000;
				2: op.new_value = 32'hFFFF_FFFF;
				default: op.new_value = '0;
			endcase
		end
		if (well_formed) begin
			a = $urandom_range(0, top);
			b = $urandom_range(0, top);
			// short spans are common, full-width ones show up too
			if ($urandom_range(0, 2) == 0) begin
				b = a + $urandom_range(0, 3);
				if (b > top)
					b = top;
			end
			if (op.action == ACT_WRITE) begin
				op.index_low = IDX_W'(a);
			end else begin
				op.index_low  = IDX_W'((a < b) ? a : b);
				op.index_high = IDX_W'((a < b) ? b : a);
			end
		end
		return op;
	endfunction

	// Size writes: setup cycle, then access cycle held until pready.
	task automatic set_size(input logic [SIZE_W-1:0] raw);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_SIZE_IN_USE;
		pwdata  <= {{(PDATA_W-SIZE_W){1'b0}}, raw};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		span_limit = span_of(raw);
	endtask

	// Hold the sender until everything is sent and answered, then let the
	// last write finish its walk before the size changes. Checked on the
	// falling edge, once the driver's updates for the cycle have landed.
	task automatic settle();
		while (request_q.size() != 0 || req_valid)
			@(negedge clk);
		while (owed_sums.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Driver: predicts on each accepted request, then either idles a burst
	// or puts the next request on the bus. Valid gets one NBA per edge.
	always @(posedge clk) begin
		logic nv;
		nv = req_valid;
		if (req_valid && item_ch.ready) begin
			apply_request(req_data);
			nv = 1'b0;
		end
		if (!nv && arst_n) begin
			if (src_gap > 0) begin
				src_gap--;
			end else if (src_idle_on && $urandom_range(0, 3) == 0) begin
				// chained bursts push the gap over every phase of the walk
				src_gap = $urandom_range(1, 16) - 1;
			end else if (request_q.size() != 0) begin
				req_data <= request_q.pop_front();
				nv = 1'b1;
			end
		end
		req_valid <= nv;
	end

	// Result side back-pressure in random bursts.
	always @(posedge clk) begin
		logic nr;
		nr = 1'b1;
		if (snk_gap > 0) begin
			snk_gap--;
			nr = 1'b0;
		end else if (snk_idle_on && $urandom_range(0, 9) == 0) begin
			snk_gap = $urandom_range(1, 16) - 1;
			nr = 1'b0;
		end
		rsp_ready <= nr;
	end

	// Monitor: every accepted result is checked against the oldest answer owed.
	always @(posedge clk) begin
		sum_answer_t want;
		if (arst_n && result_ch.valid && rsp_ready) begin
			if (owed_sums.size() == 0) begin
				report_mismatch("result with no query pending", result_ch.range_sum, '0);
			end else begin
				want = owed_sums.pop_front();
				if (result_ch.range_sum !== want.sum)
					report_mismatch("range_sum", result_ch.range_sum, want.sum);
				if (result_ch.range_error !== want.err)
					report_mismatch("range_error", 32'(result_ch.range_error),
						32'(want.err));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int ph;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset size (full array). The driver holds the first request until
		// the clearing pass is over and ready comes up.
		add_write(0, 32'h7FFF_FFFF);
		add_write(1, 32'h0000_0001);
		add_query(0, 1);                       // max positive + 1 wraps
		add_write(1023, 32'h8000_0000);
		add_query(1023, 1023);
		add_write(512, 32'hFFFF_FFFF);
		add_query(0, 1023);
		add_query(1, 512);
		add_query(5, 5);                       // never written, reads zero
		add_query(10, 9);                      // low above high
		add_query(1023, 0);
		add_write(1023, 32'hFFFF_FFFF, 10'h3FF);
		add_query(0, 1023, 32'hFFFF_FFFF);

		// Size 0 acts as one position.
		settle();
		set_size(11'd0);
		add_write(0, 32'h0000_0005);
		add_write(1, 32'h0000_0007);           // past the size: dropped
		add_query(0, 0);
		add_query(0, 1);                       // high beyond size
		add_query(1, 1);

		// Shrink: writes past the size drop, old values stay stored.
		settle();
		set_size(11'd300);
		add_write(299, 32'h0000_000B);
		add_write(300, 32'h0000_0016);
		add_query(0, 299);
		add_query(0, 300);
		add_query(290, 299);

		// Grow past max: saturates, stored values beyond 300 count again.
		settle();
		set_size(11'd1025);
		add_query(0, 1023);
		add_query(300, 300);
		add_query(1, 1);

		// Random phases: full size, a mid size, a tiny size, then raw max
		// with no idling on either side.
		for (ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: set_size(11'd1024);
				1: set_size(SIZE_W'($urandom_range(2, 1023)));
				2: set_size(SIZE_W'($urandom_range(1, 8)));
				default: begin
					src_idle_on = 1'b0;
					snk_idle_on = 1'b0;
					set_size(11'd2047);
				end
			endcase
			repeat (240) queue_request(random_request($urandom_range(0, 9) != 0));
		end

		while (request_q.size() != 0 || req_valid)
			@(negedge clk);
		while (owed_sums.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
